[rtl/dotq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dotq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MAX_OUT  = 16;
  localparam int CNT_W    = $clog2(MAX_OUT + 1);
  localparam int TIME_W   = 32;
  localparam int ID_W     = 32;
  localparam int SLOT_W   = TIME_W + ID_W;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    K_ADDED     = 3'd0,
    K_FULL      = 3'd1,
    K_DELETED   = 3'd2,
    K_NOT_FOUND = 3'd3,
    K_EXPIRED   = 3'd4,
    K_NONE_DUE  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FDEC,
    S_MDEC
  } state_t;

  // one slot handed to the compare unit per cycle
  typedef struct packed {
    logic              clear;
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              slot_v;
    logic [TIME_W-1:0] key_exp;
    logic [ID_W-1:0]   key_id;
  } scan_ctl_t;

  typedef struct packed {
    logic              best_found;
    logic [IDX_W-1:0]  best_idx;
    logic [TIME_W-1:0] best_exp;
    logic [ID_W-1:0]   best_id;
    logic              hit_found;
    logic [IDX_W-1:0]  hit_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/dotq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dotq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/dotq_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module dotq_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dotq_pkg::scan_ctl_t         ctl,
  input  logic [dotq_pkg::TIME_W-1:0] rd_exp,
  input  logic [dotq_pkg::ID_W-1:0]   rd_id,
  output dotq_pkg::scan_res_t         res
);

  logic                        best_found_r;
  logic [dotq_pkg::IDX_W-1:0]  best_idx_r;
  logic [dotq_pkg::TIME_W-1:0] best_exp_r;
  logic [dotq_pkg::ID_W-1:0]   best_id_r;
  logic                        hit_found_r;
  logic [dotq_pkg::IDX_W-1:0]  hit_idx_r;
  logic                        free_found_r;
  logic [dotq_pkg::IDX_W-1:0]  free_idx_r;

  logic take_min;
  logic take_hit;
  logic take_free;

  // strict less-than keeps the lowest index among equal keys
  assign take_min  = ctl.en && ctl.slot_v &&
                     (!best_found_r || ({rd_exp, rd_id} < {best_exp_r, best_id_r}));
  assign take_hit  = ctl.en && ctl.slot_v && !hit_found_r &&
                     (rd_exp == ctl.key_exp) && (rd_id == ctl.key_id);
  assign take_free = ctl.en && !ctl.slot_v && !free_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.clear) begin
      best_found_r <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (take_min) begin
        best_found_r <= 1'b1;
      end
      if (take_hit) begin
        hit_found_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_min) begin
      best_idx_r <= ctl.idx;
      best_exp_r <= rd_exp;
      best_id_r  <= rd_id;
    end
    if (take_hit) begin
      hit_idx_r <= ctl.idx;
    end
    if (take_free) begin
      free_idx_r <= ctl.idx;
    end
  end

  assign res.best_found = best_found_r;
  assign res.best_idx   = best_idx_r;
  assign res.best_exp   = best_exp_r;
  assign res.best_id    = best_id_r;
  assign res.hit_found  = hit_found_r;
  assign res.hit_idx    = hit_idx_r;
  assign res.free_found = free_found_r;
  assign res.free_idx   = free_idx_r;

endmodule

`default_nettype wire

[rtl/dotq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module dotq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [31:0]                 in_now_ms,
  input  logic [31:0]                 in_delay_ms,
  input  logic [31:0]                 in_del_expire,
  input  logic [31:0]                 in_del_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  out_kind,
  output logic [31:0]                 out_entry_id,
  output logic [31:0]                 out_entry_expire,
  output logic [31:0]                 out_sleep_ms,
  output logic                        out_queue_empty,
  output logic                        out_last,
  output logic                        ram_we,
  output logic [dotq_pkg::IDX_W-1:0]  ram_waddr,
  output logic [dotq_pkg::SLOT_W-1:0] ram_wdata,
  output logic [dotq_pkg::IDX_W-1:0]  ram_raddr,
  output dotq_pkg::scan_ctl_t         scan_ctl,
  input  dotq_pkg::scan_res_t         scan_res
);

  dotq_pkg::state_t state_r, state_nxt;

  logic [dotq_pkg::IDX_W-1:0]    idx_r;
  logic                          pv_r;
  logic [dotq_pkg::IDX_W-1:0]    pidx_r;
  logic                          find_r;
  dotq_pkg::op_t                 op_r;
  logic [31:0]                   now_r;
  logic [31:0]                   delay_r;
  logic [31:0]                   dexp_r;
  logic [31:0]                   did_r;
  logic [dotq_pkg::CAPACITY-1:0] valid_r;
  logic [31:0]                   next_id_r;
  logic [dotq_pkg::CNT_W-1:0]    cnt_r;
  logic                          pend_r;
  logic [31:0]                   pend_exp_r;
  logic [31:0]                   pend_id_r;
  dotq_pkg::kind_t               res_kind_r;
  logic [31:0]                   res_id_r;
  logic [31:0]                   res_exp_r;

  logic                          out_valid_r;
  dotq_pkg::kind_t               out_kind_r;
  logic [31:0]                   out_id_r;
  logic [31:0]                   out_exp_r;
  logic [31:0]                   out_sleep_r;
  logic                          out_empty_r;
  logic                          out_last_r;

  logic            accept;
  logic            scan_last;
  logic            can_out;
  logic [32:0]     sum;
  logic [31:0]     deadline;
  logic            due;
  logic [31:0]     sleep;
  logic            issue;
  logic            load_out;
  logic            take_best;
  logic            pend_clr;
  dotq_pkg::kind_t out_kind_sel;
  logic [31:0]     out_id_sel;
  logic [31:0]     out_exp_sel;
  logic            out_last_sel;

  assign in_ready  = (state_r == dotq_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign scan_last = (idx_r == dotq_pkg::IDX_W'(dotq_pkg::CAPACITY - 1));
  assign can_out   = !out_valid_r || out_ready;

  // saturate the deadline at the largest time
  assign sum      = {1'b0, now_r} + {1'b0, delay_r};
  assign deadline = sum[32] ? '1 : sum[31:0];

  assign due   = scan_res.best_found && (scan_res.best_exp <= now_r) &&
                 (cnt_r < dotq_pkg::CNT_W'(dotq_pkg::MAX_OUT));
  assign sleep = (scan_res.best_found && (scan_res.best_exp > now_r)) ?
                 (scan_res.best_exp - now_r) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dotq_pkg::S_IDLE: begin
        if (accept) begin
          case (dotq_pkg::op_t'(in_opcode))
            dotq_pkg::OP_ADD:  state_nxt = dotq_pkg::S_SCAN;
            dotq_pkg::OP_DEL:  state_nxt = dotq_pkg::S_SCAN;
            dotq_pkg::OP_TICK: state_nxt = dotq_pkg::S_SCAN;
            default:           state_nxt = dotq_pkg::S_IDLE;
          endcase
        end
      end
      dotq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = dotq_pkg::S_DRAIN;
        end
      end
      dotq_pkg::S_DRAIN: begin
        state_nxt = find_r ? dotq_pkg::S_FDEC : dotq_pkg::S_MDEC;
      end
      dotq_pkg::S_FDEC: begin
        state_nxt = dotq_pkg::S_SCAN;
      end
      dotq_pkg::S_MDEC: begin
        if (op_r == dotq_pkg::OP_TICK) begin
          if (pend_r) begin
            if (can_out) begin
              state_nxt = due ? dotq_pkg::S_SCAN : dotq_pkg::S_IDLE;
            end
          end else if (due) begin
            state_nxt = dotq_pkg::S_SCAN;
          end else if (can_out) begin
            state_nxt = dotq_pkg::S_IDLE;
          end
        end else if (can_out) begin
          state_nxt = dotq_pkg::S_IDLE;
        end
      end
      default: state_nxt = dotq_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    issue        = 1'b0;
    load_out     = 1'b0;
    take_best    = 1'b0;
    pend_clr     = 1'b0;
    out_kind_sel = res_kind_r;
    out_id_sel   = res_id_r;
    out_exp_sel  = res_exp_r;
    out_last_sel = 1'b1;
    case (state_r)
      dotq_pkg::S_SCAN: begin
        issue = 1'b1;
      end
      dotq_pkg::S_MDEC: begin
        if (op_r == dotq_pkg::OP_TICK) begin
          if (pend_r) begin
            // emit the word removed last time, with sleep from this scan
            load_out     = can_out;
            take_best    = can_out && due;
            pend_clr     = can_out && !due;
            out_kind_sel = dotq_pkg::K_EXPIRED;
            out_id_sel   = pend_id_r;
            out_exp_sel  = pend_exp_r;
            out_last_sel = !due;
          end else begin
            take_best    = due;
            load_out     = !due && can_out;
            out_kind_sel = dotq_pkg::K_NONE_DUE;
            out_id_sel   = '0;
            out_exp_sel  = '0;
          end
        end else begin
          load_out = can_out;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign ram_raddr = idx_r;
  assign ram_we    = (state_r == dotq_pkg::S_FDEC) && (op_r == dotq_pkg::OP_ADD) &&
                     scan_res.free_found;
  assign ram_waddr = scan_res.free_idx;
  assign ram_wdata = {deadline, next_id_r};

  assign scan_ctl.clear   = (state_r == dotq_pkg::S_SCAN) && (idx_r == '0);
  assign scan_ctl.en      = pv_r;
  assign scan_ctl.idx     = pidx_r;
  assign scan_ctl.slot_v  = valid_r[pidx_r];
  assign scan_ctl.key_exp = dexp_r;
  assign scan_ctl.key_id  = did_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dotq_pkg::S_IDLE;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      find_r      <= 1'b0;
      valid_r     <= '0;
      next_id_r   <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= issue;
      if (issue) begin
        idx_r <= scan_last ? '0 : idx_r + 1'b1;
      end
      if (accept) begin
        find_r <= (dotq_pkg::op_t'(in_opcode) == dotq_pkg::OP_ADD) ||
                  (dotq_pkg::op_t'(in_opcode) == dotq_pkg::OP_DEL);
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end
      if (state_r == dotq_pkg::S_FDEC) begin
        find_r <= 1'b0;
        if (ram_we) begin
          valid_r[scan_res.free_idx] <= 1'b1;
          next_id_r                  <= next_id_r + 1'b1;
        end
        if ((op_r == dotq_pkg::OP_DEL) && scan_res.hit_found) begin
          valid_r[scan_res.hit_idx] <= 1'b0;
        end
      end
      if (take_best) begin
        valid_r[scan_res.best_idx] <= 1'b0;
        pend_r                     <= 1'b1;
        cnt_r                      <= cnt_r + 1'b1;
      end
      if (pend_clr) begin
        pend_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= idx_r;
    if (accept) begin
      op_r    <= dotq_pkg::op_t'(in_opcode);
      now_r   <= in_now_ms;
      delay_r <= in_delay_ms;
      dexp_r  <= in_del_expire;
      did_r   <= in_del_id;
    end
    if (state_r == dotq_pkg::S_FDEC) begin
      if (op_r == dotq_pkg::OP_ADD) begin
        if (scan_res.free_found) begin
          res_kind_r <= dotq_pkg::K_ADDED;
          res_id_r   <= next_id_r;
          res_exp_r  <= deadline;
        end else begin
          res_kind_r <= dotq_pkg::K_FULL;
          res_id_r   <= '0;
          res_exp_r  <= '0;
        end
      end else begin
        if (scan_res.hit_found) begin
          res_kind_r <= dotq_pkg::K_DELETED;
          res_id_r   <= did_r;
          res_exp_r  <= dexp_r;
        end else begin
          res_kind_r <= dotq_pkg::K_NOT_FOUND;
          res_id_r   <= '0;
          res_exp_r  <= '0;
        end
      end
    end
    if (take_best) begin
      pend_exp_r <= scan_res.best_exp;
      pend_id_r  <= scan_res.best_id;
    end
    if (load_out) begin
      out_kind_r  <= out_kind_sel;
      out_id_r    <= out_id_sel;
      out_exp_r   <= out_exp_sel;
      out_sleep_r <= sleep;
      out_empty_r <= !scan_res.best_found;
      out_last_r  <= out_last_sel;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_entry_id     = out_id_r;
  assign out_entry_expire = out_exp_r;
  assign out_sleep_ms     = out_sleep_r;
  assign out_queue_empty  = out_empty_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_pend_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (op_r == dotq_pkg::OP_TICK))
    else $error("pending expiry outside a tick");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dotq_pkg::CNT_W'(dotq_pkg::MAX_OUT))
    else $error("expiry count overran");

  a_expired_due: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (out_kind_sel == dotq_pkg::K_EXPIRED)) |-> (pend_exp_r <= now_r))
    else $error("expired word not yet due");

  a_free_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[scan_res.free_idx])
    else $error("add overwrote a live slot");

  a_empty_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_sleep_r == '0))
    else $error("empty queue with nonzero sleep");
`endif

endmodule

`default_nettype wire

[rtl/deadline_ordered_timer_queue.sv]
// Timer queue of dotq_pkg::CAPACITY slots, ordered by deadline, then id.
// Input channel (in_valid/in_ready): opcode add, delete or tick, plus the
// current time. Result channel (out_valid/out_ready): one word per add or
// delete, one word per expired timer on tick (or one none-due word), each
// with the sleep time to the earliest deadline; out_last marks the final
// word of an item. Opcode 3 is dropped with no result.
// Every pass walks the slot RAM one entry per cycle through a single
// 64-bit compare unit. Add and delete make a find pass, then a min pass,
// before their word is loaded. A tick makes one min pass per removed
// timer plus a final one: its first word follows the first pass when
// nothing is due, else the second, and each further word follows one
// more pass. in_ready is high only between items and returns in the
// cycle after the last word is loaded. Reset clears the valid bits, the
// id counter and both channels; slot RAM contents are not cleared. When
// the receiver stalls, the held word stays on the result port, and while
// a removed timer is pending the sequencer waits before its next removal.
`timescale 1ns / 1ps
`default_nettype none

module deadline_ordered_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_delay_ms,
  input  logic [31:0] in_del_expire,
  input  logic [31:0] in_del_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_entry_id,
  output logic [31:0] out_entry_expire,
  output logic [31:0] out_sleep_ms,
  output logic        out_queue_empty,
  output logic        out_last
);

  logic                        ram_we;
  logic [dotq_pkg::IDX_W-1:0]  ram_waddr;
  logic [dotq_pkg::SLOT_W-1:0] ram_wdata;
  logic [dotq_pkg::IDX_W-1:0]  ram_raddr;
  logic [dotq_pkg::SLOT_W-1:0] ram_rdata;
  dotq_pkg::scan_ctl_t         scan_ctl;
  dotq_pkg::scan_res_t         scan_res;

  dotq_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_now_ms        (in_now_ms),
    .in_delay_ms      (in_delay_ms),
    .in_del_expire    (in_del_expire),
    .in_del_id        (in_del_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_entry_id     (out_entry_id),
    .out_entry_expire (out_entry_expire),
    .out_sleep_ms     (out_sleep_ms),
    .out_queue_empty  (out_queue_empty),
    .out_last         (out_last),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .scan_ctl         (scan_ctl),
    .scan_res         (scan_res)
  );

  dotq_ram #(
    .DEPTH (dotq_pkg::CAPACITY),
    .WIDTH (dotq_pkg::SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dotq_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (scan_ctl),
    .rd_exp (ram_rdata[dotq_pkg::SLOT_W-1:dotq_pkg::ID_W]),
    .rd_id  (ram_rdata[dotq_pkg::ID_W-1:0]),
    .res    (scan_res)
  );

endmodule

`default_nettype wire
